// ===== hdl/assert_macros.svh =====
// Assertion helpers for the haversine distance pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HAV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hav: property violated");
`define HAV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hav: forbidden condition seen");
`else
`define HAV_ASSERT(lbl, clk, rst_n, prop)
`define HAV_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/hav_pkg.sv =====
`default_nettype none

package hav_pkg;

  localparam int unsigned TRIG_ITER_DEFAULT = 24;

  // One full turn in units of 1e-7 degree.
  localparam logic [63:0] FULL_TURN = 64'd3600000000;
  // floor(2^64 / FULL_TURN), used to estimate the binary angle.
  localparam logic [32:0] RECIP_TURN = 33'd5124095576;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [32:0] PI_HALF_Q32 = 33'd6746518852;
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic [9:0] MM_PER_M = 10'd1000;

  typedef enum logic [1:0] {
    QUAD_E,
    QUAD_N,
    QUAD_W,
    QUAD_S
  } quad_e;

  // Arctangent of 2^-k in binary-angle units (2^32 is a full turn).
  function automatic logic [29:0] atan_bam(input logic [4:0] k);
    logic [29:0] r;
    case (k)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/haversine_great_circle_distance.sv =====
// Haversine great-circle distance, fully pipelined. Each transaction on the
// input stream carries two points (latitude and longitude in 1e-7 degree) and
// gives one transaction on the output stream with the haversine term a in
// Q0.32, the central angle in 2^-29 rad and the distance in millimetres for
// the sphere radius last written on the configuration port. A new pair is
// taken in every cycle while the output does not stall; the pipeline depth
// is set by the four rotation CORDIC lanes, the 32-step square roots and the
// vectoring CORDIC, one stage per step. A stall on the output freezes the
// whole pipeline. The radius is read at the distance multiplier, so write it
// only while no transaction is in flight.
`default_nettype none
`include "assert_macros.svh"

module haversine_great_circle_distance #(
  parameter int unsigned TRIG_ITERATIONS = hav_pkg::TRIG_ITER_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94], zero fill
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hav_term[32:0], central_angle[63:33], distance_mm[99:64], zero fill
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i
);
  import hav_pkg::*;

  localparam int unsigned LAT = 49 + 2 * TRIG_ITERATIONS;
  localparam int unsigned ROOT_STEPS = 32;
  localparam logic signed [34:0] TURN_S = 35'sd3600000000;

  typedef struct packed {
    logic [62:0] rem;
    logic [63:0] root;
  } root_step_t;

  function automatic logic [31:0] reduce_turn(input logic signed [32:0] v);
    logic signed [34:0] w, p1, p2, m1, r;
    w  = 35'(v);
    p1 = w + TURN_S;
    p2 = p1 + TURN_S;
    m1 = w - TURN_S;
    if (w < 0) begin
      r = (p1 < 0) ? p2 : p1;
    end else if (w >= TURN_S) begin
      r = m1;
    end else begin
      r = w;
    end
    return r[31:0];
  endfunction

  function automatic root_step_t root_step(input logic [62:0] rem,
                                           input logic [63:0] root,
                                           input logic [63:0] bitv);
    root_step_t r;
    logic [63:0] trial;
    trial = root + bitv;
    if (64'(rem) >= trial) begin
      r.rem  = 63'(64'(rem) - trial);
      r.root = (root >> 1) + bitv;
    end else begin
      r.rem  = rem;
      r.root = root >> 1;
    end
    return r;
  endfunction

  logic               en;
  logic [LAT-1:0]     vld_q;
  logic [23:0]        radius_q;

  logic signed [32:0] lat_a_q, lat_b_q, dlat_q, dlon_q;
  logic [31:0]        turn_q [4];
  logic signed [32:0] ca, cb, s1, s2;

  logic signed [65:0] cacb_q, s1sq_q, s2sq_q;
  logic signed [32:0] p30_q;
  logic [32:0]        q29_q;
  logic signed [65:0] s1x2_q, s1x2b_q, hprod_q, hsum, hclamp;
  logic [62:0]        a62_q;
  logic [32:0]        hav_d;

  logic [62:0]        sqa_rem_q [ROOT_STEPS+1];
  logic [63:0]        sqa_root_q [ROOT_STEPS+1];
  logic [62:0]        sqb_rem_q [ROOT_STEPS+1];
  logic [63:0]        sqb_root_q [ROOT_STEPS+1];
  logic [32:0]        sq_hav_q [ROOT_STEPS+1];

  logic signed [41:0] vx_q [TRIG_ITERATIONS];
  logic signed [41:0] vy_q [TRIG_ITERATIONS];
  logic signed [32:0] vz_q [TRIG_ITERATIONS];
  logic [32:0]        vh_q [TRIG_ITERATIONS];

  logic [30:0]        zc;
  logic [63:0]        cprod_q;
  logic [32:0]        c1_hav_q, c2_hav_q, c3_hav_q, c4_hav_q;
  logic [30:0]        c2_cen_q, c3_cen_q, c4_cen_q;
  logic [54:0]        dprod_q;
  logic [65:0]        dmm_q;
  logic [32:0]        out_hav_q;
  logic [30:0]        out_cen_q;
  logic [35:0]        out_dist_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {4'b0000, out_dist_q, out_cen_q, out_hav_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Differences, then reduction into one turn.
  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_a_q   <= 33'($signed(s_axis_tdata[30:0]));
      lat_b_q   <= 33'($signed(s_axis_tdata[93:63]));
      dlat_q    <= 33'($signed(s_axis_tdata[30:0])) - 33'($signed(s_axis_tdata[93:63]));
      dlon_q    <= 33'($signed(s_axis_tdata[62:31])) - 33'($signed(s_axis_tdata[125:94]));
      turn_q[0] <= reduce_turn(lat_a_q);
      turn_q[1] <= reduce_turn(lat_b_q);
      turn_q[2] <= reduce_turn(dlat_q);
      turn_q[3] <= reduce_turn(dlon_q);
    end
  end

  hav_sincos #(.ITER(TRIG_ITERATIONS), .SHIFT(32)) u_lat_a (
    .clk_i(clk_i), .en_i(en), .turn_i(turn_q[0]), .cos_o(ca), .sin_o()
  );
  hav_sincos #(.ITER(TRIG_ITERATIONS), .SHIFT(32)) u_lat_b (
    .clk_i(clk_i), .en_i(en), .turn_i(turn_q[1]), .cos_o(cb), .sin_o()
  );
  hav_sincos #(.ITER(TRIG_ITERATIONS), .SHIFT(31)) u_dlat (
    .clk_i(clk_i), .en_i(en), .turn_i(turn_q[2]), .cos_o(), .sin_o(s1)
  );
  hav_sincos #(.ITER(TRIG_ITERATIONS), .SHIFT(31)) u_dlon (
    .clk_i(clk_i), .en_i(en), .turn_i(turn_q[3]), .cos_o(), .sin_o(s2)
  );

  always_comb begin
    hsum = s1x2b_q + hprod_q;
    if (hsum < 0) begin
      hclamp = '0;
    end else if (hsum > (66'sd1 <<< 61)) begin
      hclamp = 66'sd1 <<< 61;
    end else begin
      hclamp = hsum;
    end
    hav_d = 33'((64'(a62_q) + (64'(1) << 29)) >> 30);
  end

  // Haversine sum in Q.61, clamped, then doubled to Q.62.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cacb_q         <= 66'(ca) * 66'(cb);
      s1sq_q         <= 66'(s1) * 66'(s1);
      s2sq_q         <= 66'(s2) * 66'(s2);
      p30_q          <= 33'(cacb_q >>> 30);
      q29_q          <= 33'(s2sq_q >>> 29);
      s1x2_q         <= s1sq_q <<< 1;
      hprod_q        <= 66'(p30_q) * $signed({33'd0, q29_q});
      s1x2b_q        <= s1x2_q;
      a62_q          <= {hclamp[61:0], 1'b0};
      sqa_rem_q[0]   <= a62_q;
      sqa_root_q[0]  <= '0;
      sqb_rem_q[0]   <= 63'(64'(1) << 62) - a62_q;
      sqb_root_q[0]  <= '0;
      sq_hav_q[0]    <= hav_d;
    end
  end

  // Both square roots, one result bit per stage.
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * j);
    root_step_t ra_s, rb_s;
    assign ra_s = root_step(sqa_rem_q[j], sqa_root_q[j], BITV);
    assign rb_s = root_step(sqb_rem_q[j], sqb_root_q[j], BITV);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqa_rem_q[j+1]  <= ra_s.rem;
        sqa_root_q[j+1] <= ra_s.root;
        sqb_rem_q[j+1]  <= rb_s.rem;
        sqb_root_q[j+1] <= rb_s.root;
        sq_hav_q[j+1]   <= sq_hav_q[j];
      end
    end
  end

  // Vectoring CORDIC on (sqrt(1-a), sqrt(a)) gives half the central angle.
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_vec
    logic signed [41:0] xi, yi, dx, dy;
    logic signed [32:0] zi, da;
    logic [32:0]        hi;
    if (i == 0) begin : g_init
      assign xi = $signed({2'b00, sqb_root_q[ROOT_STEPS][31:0], 8'h00});
      assign yi = $signed({2'b00, sqa_root_q[ROOT_STEPS][31:0], 8'h00});
      assign zi = '0;
      assign hi = sq_hav_q[ROOT_STEPS];
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
      assign hi = vh_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign da = $signed({3'b000, atan_bam(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en) begin
        vh_q[i] <= hi;
        if (yi > 0) begin
          vx_q[i] <= xi + dx;
          vy_q[i] <= yi - dy;
          vz_q[i] <= zi + da;
        end else begin
          vx_q[i] <= xi - dx;
          vy_q[i] <= yi + dy;
          vz_q[i] <= zi - da;
        end
      end
    end
  end

  always_comb begin
    if (vz_q[TRIG_ITERATIONS-1] < 0) begin
      zc = '0;
    end else if (vz_q[TRIG_ITERATIONS-1] > 33'sd1073741824) begin
      zc = 31'd1073741824;
    end else begin
      zc = vz_q[TRIG_ITERATIONS-1][30:0];
    end
  end

  // Angle scaling by pi/2, then radius and the millimetre factor.
  always_ff @(posedge clk_i) begin
    if (en) begin
      cprod_q    <= 64'(zc) * 64'(PI_HALF_Q32);
      c1_hav_q   <= vh_q[TRIG_ITERATIONS-1];
      c2_cen_q   <= 31'((cprod_q + (64'(1) << 31)) >> 32);
      c2_hav_q   <= c1_hav_q;
      dprod_q    <= 55'(c2_cen_q) * 55'(radius_q);
      c3_cen_q   <= c2_cen_q;
      c3_hav_q   <= c2_hav_q;
      dmm_q      <= 66'(dprod_q) * 66'(MM_PER_M);
      c4_cen_q   <= c3_cen_q;
      c4_hav_q   <= c3_hav_q;
      out_dist_q <= 36'((dmm_q + (66'(1) << 28)) >> 29);
      out_cen_q  <= c4_cen_q;
      out_hav_q  <= c4_hav_q;
    end
  end

  `HAV_ASSERT(a_hav_max, clk_i, rst_ni, m_axis_tvalid |-> (out_hav_q <= 33'h1_0000_0000))
  `HAV_ASSERT(a_angle_max, clk_i, rst_ni, m_axis_tvalid |-> (out_cen_q <= 31'd1686629714))
  `HAV_ASSERT_NEVER(a_zero_angle, clk_i, rst_ni, m_axis_tvalid && out_cen_q == '0 && out_dist_q != '0)
  `HAV_ASSERT(a_freeze, clk_i, rst_ni, !en |=> $stable(vld_q))

endmodule

`default_nettype wire

// ===== hdl/hav_sincos.sv =====
`default_nettype none

module hav_sincos #(
  parameter int unsigned ITER  = hav_pkg::TRIG_ITER_DEFAULT,
  parameter int unsigned SHIFT = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        turn_i,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);
  import hav_pkg::*;

  logic [31:0]        u1_q, u2_q;
  logic [64:0]        m_q;
  logic [32:0]        qe_d, qe2_q, qe3_q;
  logic [63:0]        p_q, num;
  logic [33:0]        rem_q;
  logic [1:0]         corr;
  logic [31:0]        t_d;
  quad_e              qd_q [ITER+1];
  logic signed [32:0] x_q [ITER+1];
  logic signed [32:0] y_q [ITER+1];
  logic signed [32:0] z_q [ITER+1];
  logic signed [32:0] cos_q, sin_q;

  // The reciprocal estimate is at most one below floor(u * 2^SHIFT / turn),
  // and rounding adds at most one more, so the remainder stays below 3 turns.
  always_comb begin
    qe_d = 33'(m_q >> (64 - SHIFT));
    num  = (64'(u2_q) << SHIFT) + (FULL_TURN >> 1);
    if (rem_q >= 34'(FULL_TURN << 1)) begin
      corr = 2'd2;
    end else if (rem_q >= 34'(FULL_TURN)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    t_d = qe3_q[31:0] + 32'(corr) + 32'h2000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q     <= turn_i;
      m_q      <= 65'(turn_i) * 65'(RECIP_TURN);
      u2_q     <= u1_q;
      qe2_q    <= qe_d;
      p_q      <= 64'(qe_d) * FULL_TURN;
      qe3_q    <= qe2_q;
      rem_q    <= 34'(num - p_q);
      qd_q[0]  <= quad_e'(t_d[31:30]);
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= $signed({3'b000, t_d[29:0]}) - 33'sd536870912;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    logic signed [32:0] dx, dy, da;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign da = $signed({3'b000, atan_bam(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[i+1] <= qd_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - da;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + da;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (qd_q[ITER])
        QUAD_E: begin
          cos_q <= x_q[ITER];
          sin_q <= y_q[ITER];
        end
        QUAD_N: begin
          cos_q <= -y_q[ITER];
          sin_q <= x_q[ITER];
        end
        QUAD_W: begin
          cos_q <= -x_q[ITER];
          sin_q <= -y_q[ITER];
        end
        default: begin
          cos_q <= y_q[ITER];
          sin_q <= -x_q[ITER];
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire
